/* rtl/fsba_pkg.sv */
// Shared types and constants for the fixed-size block allocator.
// Holds the request/response payloads, opcode and state codes, and sizing helpers.
// No dependencies.
`default_nettype none

package fsba_pkg;

   // Sizing
   localparam int MAX_BLOCKS  = 1024;
   localparam int WORD_BYTES  = 8;
   localparam int SIZE_LIMIT  = 4096;

   localparam int INDEX_W     = 10;
   localparam int LINK_W      = 11;
   localparam int COUNT_W     = 11;
   localparam int SIZE_W      = 13;
   localparam int OFFSET_W    = 22;
   localparam int POOL_W      = 23;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   // Reset values of the configuration registers
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(8);

   // Operation codes
   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_INIT  = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLOCK_COUNT = 1'b0,
      CSR_BLOCK_BYTES = 1'b1
   } csr_index_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_INIT   = 2'd1,
      ST_FINISH = 2'd2
   } state_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [INDEX_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic [INDEX_W-1:0]  granted_index;
      logic [OFFSET_W-1:0] granted_offset;
      logic [COUNT_W-1:0]  free_count;
      logic [POOL_W-1:0]   pool_bytes;
   } rsp_type;

   // Block size clamped to 1..SIZE_LIMIT and rounded up to whole words
   function automatic logic [SIZE_W-1:0] aligned_size(input logic [SIZE_W-1:0] bytes);
      logic [SIZE_W:0] b;
      logic [SIZE_W:0] r;
      b = {1'b0, bytes};
      if (b == '0) begin
         b = (SIZE_W+1)'(1);
      end
      if (b > (SIZE_W+1)'(SIZE_LIMIT)) begin
         b = (SIZE_W+1)'(SIZE_LIMIT);
      end
      r = (SIZE_W+1)'(((b + (SIZE_W+1)'(WORD_BYTES - 1)) / WORD_BYTES) * WORD_BYTES);
      return r[SIZE_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/fixed_size_block_allocator_top.sv */
// Fixed-size block allocator: free list of block indices threaded through a link RAM.
// Allocate, free and no-op: response registered by the commit in the finish state;
// requests wait for it, set by the read-then-commit pass over the link RAM port.
// Init: one link RAM write per block in the init state, then the commit in the finish
// state (0 blocks: no writes). A stalled response holds off the commit.
// Reset: list empty, free count 0, registers at 1024 blocks of 8 bytes, requests stalled;
// the link RAM is not cleared, since only written links are ever followed.
`default_nettype none

module fixed_size_block_allocator_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [fsba_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [fsba_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire fsba_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output fsba_pkg::rsp_type                        rsp_data
);

   localparam int OFF_PROD_W  = fsba_pkg::INDEX_W + fsba_pkg::SIZE_W;
   localparam int POOL_PROD_W = fsba_pkg::COUNT_W + fsba_pkg::SIZE_W;
   localparam int POOL_EXTRA  = 2 * fsba_pkg::WORD_BYTES - 1;
   localparam int POOL_RESET  = fsba_pkg::MAX_BLOCKS * fsba_pkg::WORD_BYTES + POOL_EXTRA;

   fsba_pkg::state_type                state_ff, state_in;
   logic [fsba_pkg::COUNT_W-1:0]       block_count_ff;
   logic [fsba_pkg::SIZE_W-1:0]        block_bytes_ff;
   logic [fsba_pkg::SIZE_W-1:0]        asz_ff, asz_in;
   logic [fsba_pkg::POOL_W-1:0]        pool_ff, pool_in;
   logic [fsba_pkg::LINK_W-1:0]        head_ff, head_in;
   logic [fsba_pkg::COUNT_W-1:0]       free_ff, free_in;
   fsba_pkg::opcode_type               op_ff;
   logic [fsba_pkg::INDEX_W-1:0]       idx_ff;
   logic [fsba_pkg::INDEX_W-1:0]       walk_ff;
   logic                               rsp_valid_ff;
   fsba_pkg::rsp_type                  rsp_ff, rsp_in;

   logic                               req_accept;
   logic                               out_free;
   logic                               commit;
   logic                               walk_last;
   logic [fsba_pkg::COUNT_W-1:0]       eff_count;
   logic [POOL_PROD_W-1:0]             pool_prod;
   logic [fsba_pkg::INDEX_W-1:0]       blk;
   logic [OFF_PROD_W-1:0]              off_prod;

   logic                               ram_wr_en;
   logic [fsba_pkg::INDEX_W-1:0]       ram_wr_addr;
   logic [fsba_pkg::LINK_W-1:0]        ram_wr_data;
   logic                               ram_rd_en;
   logic [fsba_pkg::INDEX_W-1:0]       ram_rd_addr;
   logic [fsba_pkg::LINK_W-1:0]        ram_rd_data;

   // Link store: entry k holds the successor of block k, as index+1, 0 for none
   fsba_ram #(
      .WIDTH (fsba_pkg::LINK_W),
      .DEPTH (fsba_pkg::MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Handshake terms
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Effective count and sizes from the registers
   assign eff_count = (block_count_ff > fsba_pkg::COUNT_W'(fsba_pkg::MAX_BLOCKS))
                    ? fsba_pkg::COUNT_W'(fsba_pkg::MAX_BLOCKS) : block_count_ff;
   assign asz_in    = fsba_pkg::aligned_size(block_bytes_ff);
   assign pool_prod = {{fsba_pkg::SIZE_W{1'b0}}, eff_count}
                    * {{fsba_pkg::COUNT_W{1'b0}}, asz_in};
   assign pool_in   = pool_prod[fsba_pkg::POOL_W-1:0] + fsba_pkg::POOL_W'(POOL_EXTRA);

   // Init walk ends on the last block of the effective count
   assign walk_last = ({1'b0, walk_ff} == (eff_count - fsba_pkg::COUNT_W'(1)));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsba_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_data.opcode == fsba_pkg::OP_INIT && eff_count != '0) begin
                  state_in = fsba_pkg::ST_INIT;
               end else begin
                  state_in = fsba_pkg::ST_FINISH;
               end
            end
         end
         fsba_pkg::ST_INIT: begin
            if (walk_last) begin
               state_in = fsba_pkg::ST_FINISH;
            end
         end
         fsba_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = fsba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fsba_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer: request stall, RAM port and commit strobe
   always_comb begin
      req_stall   = 1'b1;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      commit      = 1'b0;
      case (state_ff)
         fsba_pkg::ST_IDLE: begin
            // hold off requests while in reset
            req_stall = reset;
            if (req_valid && !reset) begin
               // allocate: fetch the successor of the head block
               if (req_data.opcode == fsba_pkg::OP_ALLOC && head_ff != '0) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = fsba_pkg::INDEX_W'(head_ff - fsba_pkg::LINK_W'(1));
               end
               // free: link the block in front of the current head
               if (req_data.opcode == fsba_pkg::OP_FREE) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = req_data.block_index;
                  ram_wr_data = head_ff;
               end
            end
         end
         fsba_pkg::ST_INIT: begin
            // block k links to block k-1; block 0 ends the list
            ram_wr_en   = 1'b1;
            ram_wr_addr = walk_ff;
            ram_wr_data = {1'b0, walk_ff};
         end
         fsba_pkg::ST_FINISH: begin
            commit = out_free;
         end
         default: begin
            commit = 1'b0;
         end
      endcase
   end

   // Grant offset: header word plus index times aligned size
   assign blk      = fsba_pkg::INDEX_W'(head_ff - fsba_pkg::LINK_W'(1));
   assign off_prod = {{fsba_pkg::SIZE_W{1'b0}}, blk} * {{fsba_pkg::INDEX_W{1'b0}}, asz_ff};

   // Commit values: new head, free count and the response
   always_comb begin
      head_in = head_ff;
      free_in = free_ff;
      rsp_in  = '0;
      case (op_ff)
         fsba_pkg::OP_ALLOC: begin
            if (head_ff != '0) begin
               head_in               = ram_rd_data;
               free_in               = (free_ff != '0) ? free_ff - fsba_pkg::COUNT_W'(1)
                                                       : free_ff;
               rsp_in.ok             = 1'b1;
               rsp_in.granted_index  = blk;
               rsp_in.granted_offset = fsba_pkg::OFFSET_W'(off_prod
                                     + OFF_PROD_W'(fsba_pkg::WORD_BYTES));
            end
         end
         fsba_pkg::OP_FREE: begin
            head_in   = {1'b0, idx_ff} + fsba_pkg::LINK_W'(1);
            free_in   = (free_ff < fsba_pkg::COUNT_W'(fsba_pkg::MAX_BLOCKS))
                      ? free_ff + fsba_pkg::COUNT_W'(1) : free_ff;
            rsp_in.ok = 1'b1;
         end
         fsba_pkg::OP_INIT: begin
            head_in   = fsba_pkg::LINK_W'(eff_count);
            free_in   = eff_count;
            rsp_in.ok = 1'b1;
         end
         default: begin
            rsp_in.ok = 1'b0;
         end
      endcase
      rsp_in.free_count = free_in;
      rsp_in.pool_bytes = pool_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fsba_pkg::ST_IDLE;
         block_count_ff <= fsba_pkg::COUNT_RESET;
         block_bytes_ff <= fsba_pkg::SIZE_RESET;
         asz_ff         <= fsba_pkg::SIZE_RESET;
         pool_ff        <= fsba_pkg::POOL_W'(POOL_RESET);
         head_ff        <= '0;
         free_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         asz_ff   <= asz_in;
         pool_ff  <= pool_in;
         // configuration writes
         if (csr_wr_en) begin
            if (csr_index == fsba_pkg::CSR_BLOCK_COUNT) begin
               block_count_ff <= csr_wdata[fsba_pkg::COUNT_W-1:0];
            end
            if (csr_index == fsba_pkg::CSR_BLOCK_BYTES) begin
               block_bytes_ff <= csr_wdata[fsba_pkg::SIZE_W-1:0];
            end
         end
         if (commit) begin
            head_ff <= head_in;
            free_ff <= free_in;
         end
         // hold the response until taken
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_data.opcode;
         idx_ff  <= req_data.block_index;
         walk_ff <= '0;
      end else if (state_ff == fsba_pkg::ST_INIT) begin
         walk_ff <= walk_ff + fsba_pkg::INDEX_W'(1);
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Init walk stays inside the effective count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fsba_pkg::ST_INIT) |-> ({1'b0, walk_ff} < eff_count))
      else $error("init walk past block count");

   // A taken request holds req_stall high in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("request taken while previous one in flight");

   // A successful allocate presents a non-zero offset
   assert property (@(posedge clock) disable iff (reset)
      (commit && op_ff == fsba_pkg::OP_ALLOC && head_ff != '0)
      |=> (rsp_valid && rsp_ff.ok && rsp_ff.granted_offset != '0))
      else $error("allocate granted without offset");

   // Head never points beyond the pool
   assert property (@(posedge clock) disable iff (reset)
      $changed(head_ff) |-> (head_ff <= fsba_pkg::LINK_W'(fsba_pkg::MAX_BLOCKS)))
      else $error("list head out of range");

endmodule

`default_nettype wire

/* rtl/fsba_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the allocator link store. No dependencies.
`default_nettype none

module fsba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port: data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* bench/tb_fixed_size_block_allocator_top.sv */
// Testbench for fixed_size_block_allocator_top: allocate, free, init and no-op requests
// with random sender gaps and response stalls, each response checked against a free-list
// predictor held here. Depends on fsba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_fixed_size_block_allocator_top;
   import fsba_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int WATCHDOG_LIMIT = 8000;
   localparam int DRAIN_CYCLES   = 8;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   csr_wr_en = 1'b0;
   csr_index_type          csr_index = CSR_BLOCK_COUNT;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;

   // Predicted allocator state and register copies
   logic [COUNT_W-1:0] count_reg   = COUNT_RESET;
   logic [SIZE_W-1:0]  bytes_reg   = SIZE_RESET;
   logic [LINK_W-1:0]  link_mem [MAX_BLOCKS];
   logic [LINK_W-1:0]  list_head   = '0;
   logic [COUNT_W-1:0] blocks_free = '0;

   rsp_type pending_rsps [$];
   int      error_count  = 0;
   int      burst_left   = 0;
   int      quiet_cycles = 0;
   int      stall_run    = 0;
   int      stall_pct    = 0;

   fixed_size_block_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Apply one request to the free list and return the response it should give
   function automatic rsp_type step_free_list(input req_type r);
      rsp_type            res;
      logic [13:0]        size;
      logic [COUNT_W-1:0] cnt;
      logic [LINK_W-1:0]  blk;
      res  = '0;
      size = {1'b0, bytes_reg};
      if (size == 0) begin
         size = 14'd1;
      end else if (size > SIZE_LIMIT) begin
         size = 14'(SIZE_LIMIT);
      end
      // round up to whole words
      size = (size + 14'(WORD_BYTES - 1)) & ~14'(WORD_BYTES - 1);
      cnt  = (count_reg > MAX_BLOCKS) ? COUNT_W'(MAX_BLOCKS) : count_reg;
      case (r.opcode)
         OP_ALLOC: begin
            if (list_head != 0) begin
               blk       = list_head - 1'b1;
               list_head = link_mem[blk[INDEX_W-1:0]];
               if (blocks_free != 0) begin
                  blocks_free = blocks_free - 1'b1;
               end
               res.ok             = 1'b1;
               res.granted_index  = blk[INDEX_W-1:0];
               res.granted_offset = OFFSET_W'(WORD_BYTES + blk * size);
            end
         end
         OP_FREE: begin
            // trusted: double frees are pushed anyway, the count saturates
            link_mem[r.block_index] = list_head;
            list_head = LINK_W'(r.block_index) + 1'b1;
            if (blocks_free < MAX_BLOCKS) begin
               blocks_free = blocks_free + 1'b1;
            end
            res.ok = 1'b1;
         end
         OP_INIT: begin
            // block k links to block k-1, block 0 ends the list
            for (int k = 0; k < cnt; k++) begin
               link_mem[k] = LINK_W'(k);
            end
            list_head   = cnt;
            blocks_free = cnt;
            res.ok      = 1'b1;
         end
         default: ;
      endcase
      res.free_count = blocks_free;
      res.pool_bytes = POOL_W'(cnt * size + 2 * WORD_BYTES - 1);
      return res;
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endfunction

   // Check each accepted response against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            $error("response with no request outstanding: %p", rsp_data);
            error_count++;
         end else begin
            want = pending_rsps.pop_front();
            compare_field("ok", 32'(want.ok), 32'(rsp_data.ok));
            compare_field("granted_index", 32'(want.granted_index),
                          32'(rsp_data.granted_index));
            compare_field("granted_offset", 32'(want.granted_offset),
                          32'(rsp_data.granted_offset));
            compare_field("free_count", 32'(want.free_count),
                          32'(rsp_data.free_count));
            compare_field("pool_bytes", 32'(want.pool_bytes),
                          32'(rsp_data.pool_bytes));
         end
      end
   end

   // Stall responses in runs of random length and density
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_run <= $urandom_range(1, 48);
         case ($urandom_range(0, 4))
            0, 1:    stall_pct <= 0;
            2:       stall_pct <= 25;
            3:       stall_pct <= 60;
            default: stall_pct <= 100;
         endcase
      end else begin
         stall_run <= stall_run - 1;
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // End the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offer one request, in bursts with random gaps, and record its prediction once taken
   task automatic send_request(input opcode_type op, input logic [INDEX_W-1:0] idx,
                               output rsp_type predicted);
      req_type r;
      int      gap;
      r.opcode      = op;
      r.block_index = idx;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = step_free_list(r);
      pending_rsps.push_back(predicted);
   endtask

   // Drop valid and hold until every response is back and the block has settled
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(input logic [CSR_DATA_W-1:0] count_word,
                                  input logic [CSR_DATA_W-1:0] bytes_word);
      wait_until_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_BLOCK_COUNT;
      csr_wdata <= count_word;
      @(posedge clock);
      csr_index <= CSR_BLOCK_BYTES;
      csr_wdata <= bytes_word;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      count_reg = count_word[COUNT_W-1:0];
      bytes_reg = bytes_word;
   endtask

   // Out of reset the list is empty: allocate fails until something is freed
   task automatic test_empty_list();
      rsp_type got;
      send_request(OP_ALLOC, '0, got);
      send_request(OP_NOP, '1, got);
      send_request(OP_FREE, '1, got);
      send_request(OP_FREE, '0, got);
      send_request(OP_ALLOC, '1, got);
      send_request(OP_ALLOC, '0, got);
      send_request(OP_ALLOC, '0, got);
   endtask

   // Init with reset registers fills all blocks; a further free saturates the count
   task automatic test_full_init();
      rsp_type got;
      send_request(OP_INIT, '0, got);
      send_request(OP_FREE, 10'd5, got);
      send_request(OP_ALLOC, '1, got);
      send_request(OP_ALLOC, '0, got);
      send_request(OP_NOP, 10'h2AA, got);
   endtask

   // Zero, saturating and smallest register values, then init and drain
   task automatic test_register_extremes();
      logic [CSR_DATA_W-1:0] counts [4] = '{13'd0, '1, 13'd1, 13'd1025};
      logic [CSR_DATA_W-1:0] sizes  [4] = '{13'd0, '1, 13'd4096, 13'd1};
      rsp_type got;
      for (int s = 0; s < 4; s++) begin
         write_registers(counts[s], sizes[s]);
         send_request(OP_INIT, '0, got);
         send_request(OP_ALLOC, '0, got);
         send_request(OP_ALLOC, '1, got);
      end
   endtask

   // A size change after init takes effect on the next offset without a rebuild
   task automatic test_size_change_after_init();
      rsp_type got;
      write_registers(13'd16, 13'd8);
      send_request(OP_INIT, '0, got);
      send_request(OP_ALLOC, '0, got);
      write_registers(13'd16, 13'd100);
      send_request(OP_ALLOC, '0, got);
      send_request(OP_FREE, 10'd15, got);
      send_request(OP_ALLOC, '0, got);
   endtask

   // Mostly allocate and free of held blocks, with stray frees, no-ops and re-inits
   task automatic test_random_traffic(input int phases, input int per_phase);
      logic [INDEX_W-1:0]    held [$];
      logic [INDEX_W-1:0]    idx;
      logic [CSR_DATA_W-1:0] count_word;
      logic [CSR_DATA_W-1:0] bytes_word;
      opcode_type            op;
      rsp_type               got;
      int                    pick;
      int                    slot;
      for (int p = 0; p < phases; p++) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            count_word = CSR_DATA_W'($urandom_range(1, 40));
         end else if (pick == 7) begin
            count_word = CSR_DATA_W'($urandom_range(41, 1024));
         end else if (pick == 8) begin
            count_word = $urandom_range(0, 1) ? 13'd0 : 13'($urandom_range(1025, 2047));
         end else begin
            count_word = 13'd1024;
         end
         // upper data bits lie outside the count register
         count_word[CSR_DATA_W-1:COUNT_W] = (CSR_DATA_W-COUNT_W)'($urandom_range(0, 3));
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            bytes_word = CSR_DATA_W'($urandom_range(1, 64));
         end else if (pick == 6) begin
            bytes_word = CSR_DATA_W'($urandom_range(65, 4096));
         end else if (pick == 7) begin
            bytes_word = CSR_DATA_W'($urandom_range(4097, 8191));
         end else if (pick == 8) begin
            bytes_word = 13'd0;
         end else begin
            bytes_word = 13'd4096;
         end
         write_registers(count_word, bytes_word);

         for (int n = 0; n < per_phase; n++) begin
            pick = (n == 0 && $urandom_range(0, 7) != 0) ? -1 : $urandom_range(0, 99);
            idx  = INDEX_W'($urandom_range(0, MAX_BLOCKS - 1));
            if (pick < 0 || pick >= 97) begin
               op = OP_INIT;
               held.delete();
            end else if (pick < 45 || (pick < 80 && held.size() == 0)) begin
               op = OP_ALLOC;
            end else if (pick < 80) begin
               op   = OP_FREE;
               slot = $urandom_range(0, held.size() - 1);
               idx  = held[slot];
               held.delete(slot);
            end else if (pick < 90) begin
               op = OP_FREE;
            end else begin
               op = OP_NOP;
            end
            send_request(op, idx, got);
            if (op == OP_ALLOC && got.ok) begin
               held.push_back(got.granted_index);
            end
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_full_init();
      test_register_extremes();
      test_size_change_after_init();
      test_random_traffic(12, 125);
      wait_until_idle();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/fsba_pkg.sv
rtl/fsba_ram.sv
rtl/fixed_size_block_allocator_top.sv
bench/tb_fixed_size_block_allocator_top.sv
